### hdl/g3d_pkg.sv
// ----------------------------------------------------------------------------
// g3d_pkg
// Shared types and constants for the trivariate Gaussian density evaluator.
// ----------------------------------------------------------------------------
package g3d_pkg;

	localparam int G3D_COORD_WIDTH_DEF = 16;

	localparam int CFG_W    = 48;
	localparam int CFG_IDX_W = 2;
	localparam int AMP_W    = 24;
	localparam int DENS_W   = 24;
	localparam int MEAN_W   = 16;
	localparam int COEF_W   = 16;

	// datapath widths
	localparam int DIFF_W   = 21;               // saturated difference, 12 frac bits
	localparam int SQ_W     = 2 * DIFF_W;       // product of two differences
	localparam int TERM_W   = SQ_W + COEF_W + 1; // one term of q, doubled cross included
	localparam int Q_W      = TERM_W + 1;       // quadratic form, 32 frac bits
	localparam int QS_W     = 28;               // q below cutoff, 24 frac bits
	localparam int T_W      = 29;               // q * log2(e), 24 frac bits
	localparam int N_W      = 5;                // integer part of the exponent
	localparam int F_W      = 24;               // fraction of the exponent
	localparam int U_W      = 30;               // series argument, Q0.30
	localparam int P_W      = 31;               // series value, Q0.30 up to 1.0
	localparam int MAG_W    = 34;               // reciprocal constants
	localparam int MAG_SH   = 33;
	localparam int SH_W     = 6;
	localparam int E16_W    = 17;               // Q0.16 factor up to 1.0

	localparam logic signed [31:0] DIFF_MAX = 32'sd1048575;
	localparam logic signed [31:0] DIFF_MIN = -32'sd1048576;

	localparam logic [Q_W-2:0]   Q_CUTOFF  = (Q_W-1)'(12) << 32;
	localparam logic [30:0]      LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0]      LN2_Q30   = 30'd744261118;
	localparam logic [P_W-1:0]   ONE_Q30   = P_W'(1) << 30;
	localparam logic [SH_W-1:0]  E_SHIFT_BASE = SH_W'(14);
	localparam logic [E16_W-1:0] E16_ONE   = E16_W'(1) << 16;
	localparam logic [DENS_W-1:0] DENS_MAX = '1;

	// series length and floor(2^33 / k) + 1 for exact division by k
	localparam int HZ_STEPS = 9;
	localparam logic [MAG_W-1:0] HZ_MAGIC [1:HZ_STEPS] = '{
		34'd8589934593,
		34'd4294967297,
		34'd2863311531,
		34'd2147483649,
		34'd1717986919,
		34'd1431655766,
		34'd1227133514,
		34'd1073741825,
		34'd954437177
	};

	// exp unit: two entry stages, two per series step, one rounding stage
	localparam int EXP_DEPTH   = 2 + 2 * HZ_STEPS + 1;
	localparam int G3D_LATENCY = 6 + EXP_DEPTH + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE = 2'd0,
		REG_MEAN_XYZ  = 2'd1,
		REG_DIAG      = 2'd2,
		REG_CROSS     = 2'd3
	} g3d_reg_t;

	typedef struct packed {
		logic neg;   // quadratic form below zero
		logic big;   // quadratic form at or above the cutoff
		logic sat;   // a difference was saturated
	} g3d_flags_t;

	typedef struct packed {
		logic [N_W-1:0] n;
		logic [U_W-1:0] u;
		g3d_flags_t     flags;
	} g3d_side_t;

endpackage

### hdl/g3d_exp_pipe.sv
// ----------------------------------------------------------------------------
// g3d_exp_pipe
// Pipelined exp(-q) in Q0.16: base-2 split, nine-step Horner series, rounding.
// ----------------------------------------------------------------------------
module g3d_exp_pipe
	import g3d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [QS_W-1:0]   in_qs,
	input  g3d_flags_t        in_flags,
	output logic              out_valid,
	output logic [E16_W-1:0]  out_e16,
	output g3d_flags_t        out_flags
);

	localparam int NSTG = 2 * HZ_STEPS;

	logic                 vld_e1, vld_e2;
	logic [T_W-1:0]       t_e1;
	g3d_flags_t           flags_e1;
	g3d_side_t            side_e2;
	logic [QS_W+30:0]     t_full;
	logic [F_W+U_W-1:0]   u_full;

	logic                 hz_vld_s  [NSTG];
	g3d_side_t            hz_side_s [NSTG];
	logic [U_W-1:0]       hz_x_s    [HZ_STEPS];
	logic [P_W-1:0]       hz_p_s    [HZ_STEPS];

	logic [SH_W-1:0]      shift;
	logic [31:0]          rnd_sum;
	logic [31:0]          e_full;
	logic [E16_W-1:0]     e16_nx;

	assign t_full = (QS_W+31)'(in_qs) * (QS_W+31)'(LOG2E_Q30);
	assign u_full = (F_W+U_W)'(t_e1[F_W-1:0]) * (F_W+U_W)'(LN2_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e1 <= 1'b0;
			vld_e2 <= 1'b0;
		end else begin
			vld_e1 <= in_valid;
			vld_e2 <= vld_e1;
		end
	end

	always_ff @(posedge clk) begin
		t_e1          <= t_full[QS_W+30:30];
		flags_e1      <= in_flags;
		side_e2.n     <= t_e1[T_W-1:F_W];
		side_e2.u     <= u_full[F_W+U_W-1:F_W];
		side_e2.flags <= flags_e1;
	end

	// p = 1 - (u*p)/k for k = 9 down to 1; each step is a multiply stage
	// followed by a reciprocal-multiply stage
	for (genvar j = 0; j < HZ_STEPS; j++) begin : g_step
		logic [P_W-1:0]       p_in;
		g3d_side_t            side_in;
		logic                 vld_in;
		logic [U_W+P_W-1:0]   up;
		logic [63:0]          xm;

		if (j == 0) begin : g_first
			assign p_in    = ONE_Q30;
			assign side_in = side_e2;
			assign vld_in  = vld_e2;
		end else begin : g_next
			assign p_in    = hz_p_s[j-1];
			assign side_in = hz_side_s[2*j-1];
			assign vld_in  = hz_vld_s[2*j-1];
		end

		assign up = (U_W+P_W)'(side_in.u) * (U_W+P_W)'(p_in);
		assign xm = 64'(hz_x_s[j]) * 64'(HZ_MAGIC[HZ_STEPS-j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hz_vld_s[2*j]   <= 1'b0;
				hz_vld_s[2*j+1] <= 1'b0;
			end else begin
				hz_vld_s[2*j]   <= vld_in;
				hz_vld_s[2*j+1] <= hz_vld_s[2*j];
			end
		end

		always_ff @(posedge clk) begin
			hz_x_s[j]        <= up[U_W+29:30];
			hz_side_s[2*j]   <= side_in;
			hz_p_s[j]        <= ONE_Q30 - P_W'(xm[U_W+MAG_SH-1:MAG_SH]);
			hz_side_s[2*j+1] <= hz_side_s[2*j];
		end
	end

	// 2^-n scaling folded into the Q0.30 -> Q0.16 rounding shift
	always_comb begin
		shift   = E_SHIFT_BASE + SH_W'(hz_side_s[NSTG-1].n);
		rnd_sum = 32'(hz_p_s[HZ_STEPS-1]) + (32'd1 << (shift - SH_W'(1)));
		e_full  = rnd_sum >> shift;
		priority if (hz_side_s[NSTG-1].flags.neg) begin
			e16_nx = E16_ONE;
		end else if (hz_side_s[NSTG-1].flags.big) begin
			e16_nx = '0;
		end else begin
			e16_nx = e_full[E16_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= hz_vld_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		out_e16   <= e16_nx;
		out_flags <= hz_side_s[NSTG-1].flags;
	end

endmodule

### hdl/gaussian_3d_density_eval_core.sv
// ----------------------------------------------------------------------------
// gaussian_3d_density_eval_core
// Trivariate Gaussian density: amplitude * exp(-q) for one 3-D point a clock.
// ----------------------------------------------------------------------------
// One point is taken at every clock edge with start high; busy is always low.
// Each result appears on density/clipped for exactly one cycle with done high,
// in the order its points were taken; there is no way to hold it off, so the
// receiver must take every beat. The pipeline is mostly the exponential: nine
// Horner steps of two register stages each, behind six stages of difference,
// products, the adder tree and classification of the quadratic form.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data and
// must only change while no point is in flight.
// ----------------------------------------------------------------------------
module gaussian_3d_density_eval_core
	import g3d_pkg::*;
#(
	parameter int COORD_WIDTH = G3D_COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	output logic                          done,
	output logic [DENS_W-1:0]             density,
	output logic                          clipped
);

	localparam int DXW = ((COORD_WIDTH > 20) ? COORD_WIDTH : 20) + 1;
	localparam logic signed [DXW-1:0] D_HI = DXW'(DIFF_MAX);
	localparam logic signed [DXW-1:0] D_LO = DXW'(DIFF_MIN);

	logic [AMP_W-1:0] amplitude_q;
	logic [CFG_W-1:0] mean_q, diag_q, cross_q;

	logic signed [COORD_WIDTH-1:0] coord [3];
	logic signed [DXW-1:0]         diff  [3];
	logic signed [DIFF_W-1:0]      d_nx  [3];
	logic                          sat_nx;

	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [DIFF_W-1:0]  d_s1  [3];
	logic signed [SQ_W-1:0]    sq_s2 [3];
	logic signed [SQ_W-1:0]    xp_s2 [3];
	logic signed [TERM_W-1:0]  dt_s3 [3];
	logic signed [TERM_W-1:0]  ct_s3 [3];
	logic signed [Q_W-1:0]     ps_s4 [3];
	logic signed [Q_W-1:0]     q_s5;
	logic                      sat_s1, sat_s2, sat_s3, sat_s4, sat_s5;
	logic [QS_W-1:0]           qs_s6;
	g3d_flags_t                flags_s6;

	logic                      ex_valid;
	logic [E16_W-1:0]          ex_e16;
	g3d_flags_t                ex_flags;
	logic [AMP_W+E16_W-1:0]    dens_full;
	logic [DENS_W:0]           dens_wide;

	assign busy = 1'b0;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= '0;
			mean_q      <= '0;
			diag_q      <= '0;
			cross_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (g3d_reg_t'(cfg_index))
				REG_AMPLITUDE: amplitude_q <= cfg_data[AMP_W-1:0];
				REG_MEAN_XYZ:  mean_q      <= cfg_data;
				REG_DIAG:      diag_q      <= cfg_data;
				REG_CROSS:     cross_q     <= cfg_data;
			endcase
		end
	end

	// stage 1: differences, saturated to 21 bits
	assign coord[0] = coord_x;
	assign coord[1] = coord_y;
	assign coord[2] = coord_z;

	always_comb begin
		sat_nx = 1'b0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = DXW'(coord[i]) - DXW'($signed(mean_q[MEAN_W*i +: MEAN_W]));
			if (diff[i] > D_HI) begin
				d_nx[i] = D_HI[DIFF_W-1:0];
				sat_nx  = 1'b1;
			end else if (diff[i] < D_LO) begin
				d_nx[i] = D_LO[DIFF_W-1:0];
				sat_nx  = 1'b1;
			end else begin
				d_nx[i] = diff[i][DIFF_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		d_s1   <= d_nx;
		sat_s1 <= sat_nx;
		// stage 2: squares and cross products (xy, yz, zx)
		sq_s2[0] <= d_s1[0] * d_s1[0];
		sq_s2[1] <= d_s1[1] * d_s1[1];
		sq_s2[2] <= d_s1[2] * d_s1[2];
		xp_s2[0] <= d_s1[0] * d_s1[1];
		xp_s2[1] <= d_s1[1] * d_s1[2];
		xp_s2[2] <= d_s1[2] * d_s1[0];
		sat_s2   <= sat_s1;
		// stage 3: weight by the precisions, cross terms doubled
		for (int i = 0; i < 3; i++) begin
			dt_s3[i] <= sq_s2[i] * $signed(diag_q[COEF_W*i +: COEF_W]);
			ct_s3[i] <= (xp_s2[i] * $signed(cross_q[COEF_W*i +: COEF_W])) <<< 1;
		end
		sat_s3 <= sat_s2;
		// stages 4 and 5: adder tree
		for (int i = 0; i < 3; i++) begin
			ps_s4[i] <= dt_s3[i] + ct_s3[i];
		end
		sat_s4 <= sat_s3;
		q_s5   <= ps_s4[0] + ps_s4[1] + ps_s4[2];
		sat_s5 <= sat_s4;
		// stage 6: classify q, drop to 24 fraction bits
		flags_s6.neg <= q_s5[Q_W-1];
		flags_s6.big <= !q_s5[Q_W-1] && (q_s5[Q_W-2:0] >= Q_CUTOFF);
		flags_s6.sat <= sat_s5;
		qs_s6        <= q_s5[QS_W+7:8];
	end

	g3d_exp_pipe u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.in_qs     (qs_s6),
		.in_flags  (flags_s6),
		.out_valid (ex_valid),
		.out_e16   (ex_e16),
		.out_flags (ex_flags)
	);

	// output stage: scale by amplitude, round over 16 bits
	assign dens_full = (AMP_W+E16_W)'(amplitude_q) * (AMP_W+E16_W)'(ex_e16)
		+ (AMP_W+E16_W)'(16'h8000);
	assign dens_wide = dens_full[AMP_W+E16_W-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dens_wide[DENS_W]) begin
			density <= DENS_MAX;
		end else begin
			density <= dens_wide[DENS_W-1:0];
		end
		clipped <= ex_flags.neg || ex_flags.sat || dens_wide[DENS_W];
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##G3D_LATENCY done)
		else $error("result beat missing at fixed latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s6, EXP_DEPTH + 1))
		else $error("result beat without a point in flight");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (density <= $past(amplitude_q)))
		else $error("density above amplitude");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gaussian_3d_density_eval_core. It starts with a
// short table of directed points and register writes, then runs random
// register settings with points streamed in bursts, most of them near the
// configured mean. Each beat is checked by a table value or bench model.
// ----------------------------------------------------------------------------
module tb
	import g3d_pkg::*;
();

	localparam int COORD_W    = G3D_COORD_WIDTH_DEF;
	localparam int PHASES     = 12;
	localparam int PHASE_PTS  = 125;
	localparam int IDLE_LIMIT = 1000;
	localparam int MAX_NOTES  = 50;

	typedef logic [63:0] u64_t;

	// exponential constants: log2(e), ln(2) and 1.0, all Q2.30 / Q0.30
	localparam u64_t   K_LOG2E = 64'd1549082005;
	localparam u64_t   K_LN2   = 64'd744261118;
	localparam u64_t   K_ONE   = 64'd1 << 30;
	localparam longint K_QCUT  = longint'(12) << 32;
	localparam longint K_DMAX  = 1048575;
	localparam longint K_DMIN  = -1048576;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [DENS_W-1:0] density;
		logic              clipped;
	} density_beat_t;

	typedef struct {
		bit            is_cfg;
		g3d_reg_t      idx;
		logic [CFG_W-1:0] data;
		coord_t        x;
		coord_t        y;
		coord_t        z;
		bit            fixed;
		density_beat_t want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 start = 1'b0;
	logic                 busy;
	coord_t               coord_x = '0;
	coord_t               coord_y = '0;
	coord_t               coord_z = '0;
	logic                 done;
	logic [DENS_W-1:0]    density;
	logic                 clipped;

	// bench copy of the registers
	logic [AMP_W-1:0] amp_r   = '0;
	logic [CFG_W-1:0] mean_r  = '0;
	logic [CFG_W-1:0] diag_r  = '0;
	logic [CFG_W-1:0] cross_r = '0;

	density_beat_t pending_densities [$];
	stim_row_t     stim_tbl [$];
	int            mismatches = 0;
	int            idle_cycles = 0;

	gaussian_3d_density_eval_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z),
		.done      (done),
		.density   (density),
		.clipped   (clipped)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// density model
	// ------------------------------------------------------------------------
	function automatic longint coef(logic [CFG_W-1:0] r, int k);
		return longint'($signed(r[16*k +: 16]));
	endfunction

	function automatic longint sat_diff(longint c, longint m, inout bit clip);
		longint d;
		d = c - m;
		if (d > K_DMAX) begin
			clip = 1'b1;
			return K_DMAX;
		end
		if (d < K_DMIN) begin
			clip = 1'b1;
			return K_DMIN;
		end
		return d;
	endfunction

	// exp(-q) in Q0.16 for q >= 0 (32 fraction bits), as 2^-(q*log2 e)
	function automatic u64_t exp_neg_q16(longint q);
		u64_t qs, t, n, f, u, p, sh;
		int   k;
		if (q >= K_QCUT)
			return 64'd0;
		qs = $unsigned(q) >> 8;
		t  = (qs * K_LOG2E) >> 30;
		n  = t >> 24;
		f  = t & 64'hFF_FFFF;
		u  = (f * K_LN2) >> 24;
		p  = K_ONE;
		for (k = 9; k >= 1; k--)
			p = K_ONE - ((u * p) >> 30) / u64_t'(k);
		sh = 64'd14 + n;
		return (p + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic density_beat_t predict_density(coord_t x, coord_t y, coord_t z);
		density_beat_t r;
		bit            clip;
		longint        dx, dy, dz, q;
		u64_t          e16, d;
		clip = 1'b0;
		dx = sat_diff(longint'(x), coef(mean_r, 0), clip);
		dy = sat_diff(longint'(y), coef(mean_r, 1), clip);
		dz = sat_diff(longint'(z), coef(mean_r, 2), clip);
		q = dx * dx * coef(diag_r, 0)
		  + dy * dy * coef(diag_r, 1)
		  + dz * dz * coef(diag_r, 2)
		  + 2 * dx * dy * coef(cross_r, 0)
		  + 2 * dy * dz * coef(cross_r, 1)
		  + 2 * dz * dx * coef(cross_r, 2);
		if (q < 0) begin
			clip = 1'b1;
			e16  = 64'd1 << 16;
		end else begin
			e16 = exp_neg_q16(q);
		end
		d = (u64_t'(amp_r) * e16 + 64'h8000) >> 16;
		if (d > 64'hFF_FFFF) begin
			d    = 64'hFF_FFFF;
			clip = 1'b1;
		end
		r.density = d[DENS_W-1:0];
		r.clipped = clip;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// random values
	// ------------------------------------------------------------------------
	function automatic logic [CFG_W-1:0] rand48();
		u64_t v;
		v = {$urandom(), $urandom()};
		return v[CFG_W-1:0];
	endfunction

	// positive precisions from 1/16 to 4.0
	function automatic logic [CFG_W-1:0] small_diag();
		return {16'($urandom_range(16, 1024)), 16'($urandom_range(16, 1024)),
			16'($urandom_range(16, 1024))};
	endfunction

	function automatic logic [CFG_W-1:0] small_cross();
		return {16'(int'($urandom_range(0, 256)) - 128), 16'(int'($urandom_range(0, 256)) - 128),
			16'(int'($urandom_range(0, 256)) - 128)};
	endfunction

	function automatic coord_t near_mean(logic [15:0] m, int span);
		int v;
		v = int'($signed(m)) + int'($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return coord_t'(v);
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic note_mismatch(string what, u64_t got, u64_t want);
		if (mismatches < MAX_NOTES)
			$display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		density_beat_t w;
		if (arst_n && done) begin
			if (pending_densities.size() == 0) begin
				note_mismatch("density beat with nothing pending", density, 0);
			end else begin
				w = pending_densities.pop_front();
				if (density !== w.density)
					note_mismatch("density", density, w.density);
				if (clipped !== w.clipped)
					note_mismatch("clipped", clipped, w.clipped);
			end
		end
	end

	// watchdog: cycles with no beat in either direction and no register write
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------------
	task automatic write_reg(g3d_reg_t idx, logic [CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_AMPLITUDE: amp_r   = v[AMP_W-1:0];
			REG_MEAN_XYZ:  mean_r  = v;
			REG_DIAG:      diag_r  = v;
			REG_CROSS:     cross_r = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// leaves start high; the caller lowers it when a gap follows
	task automatic send_point(coord_t x, coord_t y, coord_t z, bit fixed, density_beat_t want);
		start   <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do @(posedge clk); while (busy);
		pending_densities.push_back(fixed ? want : predict_density(x, y, z));
	endtask

	task automatic pause_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_densities.size() != 0);
	endtask

	task automatic tbl_cfg(g3d_reg_t idx, logic [CFG_W-1:0] v);
		stim_row_t r;
		r = '{is_cfg: 1'b1, idx: idx, data: v, x: '0, y: '0, z: '0, fixed: 1'b0, want: '0};
		stim_tbl.push_back(r);
	endtask

	task automatic tbl_pt(int x, int y, int z);
		stim_row_t r;
		r = '{is_cfg: 1'b0, idx: REG_AMPLITUDE, data: '0, x: coord_t'(x), y: coord_t'(y),
			z: coord_t'(z), fixed: 1'b0, want: '0};
		stim_tbl.push_back(r);
	endtask

	task automatic tbl_fix(int x, int y, int z, logic [DENS_W-1:0] d, logic c);
		stim_row_t r;
		r = '{is_cfg: 1'b0, idx: REG_AMPLITUDE, data: '0, x: coord_t'(x), y: coord_t'(y),
			z: coord_t'(z), fixed: 1'b1, want: '{density: d, clipped: c}};
		stim_tbl.push_back(r);
	endtask

	initial begin
		logic [CFG_W-1:0] amp_v, mean_v, diag_v, cross_v;
		coord_t           x, y, z;
		int               burst_left;
		int               span;

		// registers at reset: zero amplitude, zero form
		tbl_fix(0, 0, 0, 24'd0, 1'b0);
		tbl_fix(32767, -32768, 32767, 24'd0, 1'b0);
		// amplitude write masked to 24 bits
		tbl_cfg(REG_AMPLITUDE, 48'hFFFF_FFFF_FFFF);
		tbl_fix(0, 0, 0, 24'hFF_FFFF, 1'b0);
		tbl_fix(-32768, -32768, -32768, 24'hFF_FFFF, 1'b0);
		// largest precisions: far points fall past the cutoff
		tbl_cfg(REG_DIAG, 48'h7FFF_7FFF_7FFF);
		tbl_fix(32767, 0, 0, 24'd0, 1'b0);
		tbl_fix(-32768, -32768, -32768, 24'd0, 1'b0);
		tbl_fix(0, 0, 0, 24'hFF_FFFF, 1'b0);
		tbl_pt(1, 0, 0);
		tbl_pt(0, 64, -64);
		// negative form: factor held at one, clip set
		tbl_cfg(REG_DIAG, 48'hFFFF_FFFF_FFFF);
		tbl_fix(4096, 0, 0, 24'hFF_FFFF, 1'b1);
		tbl_fix(0, 0, -1, 24'hFF_FFFF, 1'b1);
		// unit precisions, either side of the q = 12 cutoff
		tbl_cfg(REG_DIAG, 48'h0100_0100_0100);
		tbl_cfg(REG_AMPLITUDE, 48'd1000000);
		tbl_pt(4096, 0, 0);
		tbl_pt(0, -4096, 0);
		tbl_pt(2048, 2048, -2048);
		tbl_pt(0, 0, 14188);
		tbl_pt(0, 0, 14189);
		// means, z at the top of its range
		tbl_cfg(REG_MEAN_XYZ, {16'h7FFF, 16'hF000, 16'h1000});
		tbl_fix(4096, -4096, 32767, 24'd1000000, 1'b0);
		tbl_fix(-32768, 32767, -32768, 24'd0, 1'b0);
		tbl_cfg(REG_CROSS, 48'h8000_8000_8000);
		tbl_pt(4096 + 512, -4096 + 512, 32767 - 512);
		tbl_pt(4096 + 512, -4096 - 512, 32767);
		tbl_cfg(REG_CROSS, 48'h7FFF_7FFF_7FFF);
		tbl_pt(4096 + 8, -4096 + 8, 32767 - 8);
		tbl_pt(4096, -4096, 32766);
		tbl_cfg(REG_AMPLITUDE, 48'd1);
		tbl_fix(4096, -4096, 32767, 24'd1, 1'b0);
		tbl_pt(4096 + 300, -4096, 32767);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tbl[i]) begin
			if (stim_tbl[i].is_cfg) begin
				pause_until_drained();
				write_reg(stim_tbl[i].idx, stim_tbl[i].data);
			end else begin
				send_point(stim_tbl[i].x, stim_tbl[i].y, stim_tbl[i].z, stim_tbl[i].fixed,
					stim_tbl[i].want);
			end
		end

		burst_left = $urandom_range(1, 12);
		for (int ph = 0; ph < PHASES; ph++) begin
			pause_until_drained();
			mean_v = rand48();
			case (ph % 6)
				0: begin
					amp_v   = 48'($urandom_range(0, 24'hFF_FFFF));
					diag_v  = small_diag();
					cross_v = '0;
				end
				1: begin
					amp_v   = 48'($urandom_range(0, 24'hFF_FFFF));
					diag_v  = small_diag();
					cross_v = small_cross();
				end
				2: begin
					amp_v   = rand48();
					diag_v  = rand48();
					cross_v = rand48();
				end
				3: begin
					amp_v   = 48'hFF_FFFF;
					diag_v  = small_diag();
					cross_v = small_cross();
				end
				4: begin
					amp_v   = 48'($urandom_range(0, 15));
					diag_v  = small_diag();
					cross_v = small_cross();
				end
				default: begin
					amp_v   = 48'($urandom_range(0, 24'hFF_FFFF));
					diag_v  = '0;
					cross_v = rand48();
				end
			endcase
			write_reg(REG_AMPLITUDE, amp_v);
			write_reg(REG_MEAN_XYZ, mean_v);
			write_reg(REG_DIAG, diag_v);
			write_reg(REG_CROSS, cross_v);

			for (int i = 0; i < PHASE_PTS; i++) begin
				// mostly points near the mean, where the exponential is live
				if ($urandom_range(0, 3) != 0) begin
					span = $urandom_range(6, 14);
					x = near_mean(mean_r[15:0], span);
					y = near_mean(mean_r[31:16], span);
					z = near_mean(mean_r[47:32], span);
				end else begin
					x = coord_t'($urandom());
					y = coord_t'($urandom());
					z = coord_t'($urandom());
				end
				send_point(x, y, z, 1'b0, '0);
				burst_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 39) == 0) begin
						pause_until_drained();
					end else begin
						start <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
					end
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
				end
			end
		end

		pause_until_drained();
		repeat (G3D_LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && pending_densities.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
